FILE: src/lsfw_pkg.sv
// Shared types and constants of the LCD serial frame writer.
// Used by the interfaces, the controller, the datapath and the top level.
package lsfw_pkg;

  localparam int OP_W    = 3;
  localparam int VALUE_W = 16;
  localparam int ROW_W   = 3;
  localparam int COL_W   = 4;
  localparam int BYTE_W  = 8;
  localparam int NDIG_MAX = 5;

  localparam logic [OP_W-1:0] OP_CMD   = 3'd0;
  localparam logic [OP_W-1:0] OP_DATA  = 3'd1;
  localparam logic [OP_W-1:0] OP_CURS  = 3'd2;
  localparam logic [OP_W-1:0] OP_NUM4  = 3'd3;
  localparam logic [OP_W-1:0] OP_NUM5  = 3'd4;

  localparam logic [BYTE_W-1:0] SYNC_CMD  = 8'hF8;
  localparam logic [BYTE_W-1:0] SYNC_DATA = 8'hFA;
  localparam logic [BYTE_W-1:0] NIB_MASK  = 8'hF0;
  localparam logic [BYTE_W-1:0] ASCII_0   = 8'h30;

  localparam logic [ROW_W-1:0] ROW_1 = 3'd1;
  localparam logic [ROW_W-1:0] ROW_2 = 3'd2;
  localparam logic [ROW_W-1:0] ROW_3 = 3'd3;
  localparam logic [ROW_W-1:0] ROW_4 = 3'd4;

  localparam logic [BYTE_W-1:0] ROW1_BASE = 8'h80;
  localparam logic [BYTE_W-1:0] ROW2_BASE = 8'h90;
  localparam logic [BYTE_W-1:0] ROW3_BASE = 8'h88;
  localparam logic [BYTE_W-1:0] ROW4_BASE = 8'h98;

  // x / 10 == (x * DIV10_MUL) >> DIV10_SHIFT for every 16-bit x
  localparam logic [16:0] DIV10_MUL   = 17'd52429;
  localparam int          DIV10_SHIFT = 19;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } lsfw_state_t;

  typedef struct packed {
    logic load;       // capture the request, start digit conversion
    logic conv_step;  // run one divide-by-ten step
    logic advance;    // current byte taken, move to the next
  } lsfw_cmd_t;

  typedef struct packed {
    logic in_op_ok;   // incoming op is a known code
    logic conv_busy;  // digits still being produced
    logic byte_ok;    // current byte can be shown
    logic byte_last;  // current byte ends the request
  } lsfw_stat_t;

endpackage

FILE: src/lsfw_if.sv
// Valid/ready channel interfaces of the LCD serial frame writer.
// Depends on lsfw_pkg for field widths.
interface lsfw_in_if import lsfw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [VALUE_W-1:0] value;
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   col;

  modport source (output valid, op, value, row, col, input ready);
  modport sink   (input valid, op, value, row, col, output ready);
endinterface

interface lsfw_out_if import lsfw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] serial_byte;
  logic              last;

  modport source (output valid, serial_byte, last, input ready);
  modport sink   (input valid, serial_byte, last, output ready);
endinterface

FILE: src/lcd_serial_frame_writer.sv
// LCD serial frame writer top level: one request in, 3, 15 or 18 bytes out.
// Latency: first byte is offered the cycle after a request is taken.
// Throughput: one byte per cycle while out is ready and no digit is still being
// converted, so the first digit may wait; a new request is taken only from idle.
// Reset: rst_n synchronous, active low; returns to idle, drops any request.
// Depends on lsfw_pkg, lsfw_if, lsfw_ctrl and lsfw_dp.
module lcd_serial_frame_writer import lsfw_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  lsfw_in_if.sink    in_req,
  lsfw_out_if.source out_rsp
);

  // Command and status between the sequencer and the datapath
  lsfw_cmd_t  cmd;
  lsfw_stat_t stat;
  logic       in_ready;
  logic       out_valid;

  // Hold each request until its last byte is taken; take the next only
  // from idle. Unknown op codes are taken and dropped with no output.
  lsfw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Capture the request, convert numbers to ASCII digits one per cycle
  // while the cursor frame goes out, then frame every byte as sync,
  // high nibble, low nibble.
  lsfw_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_op           (in_req.op),
    .in_value        (in_req.value),
    .in_row          (in_req.row),
    .in_col          (in_req.col),
    .out_serial_byte (out_rsp.serial_byte),
    .out_last        (out_rsp.last),
    .cmd             (cmd),
    .stat            (stat)
  );

  assign in_req.ready  = in_ready;
  assign out_rsp.valid = out_valid;

endmodule

FILE: src/lsfw_ctrl.sv
// Controller state machine of the LCD serial frame writer.
// Depends on lsfw_pkg; drives commands to lsfw_dp from its status.
module lsfw_ctrl import lsfw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  lsfw_stat_t stat,
  output lsfw_cmd_t  cmd
);

  lsfw_state_t state_r, state_nxt;

  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    out_valid     = (state_r == ST_EMIT) && stat.byte_ok;
    cmd.load      = in_ready && in_valid && stat.in_op_ok;
    cmd.conv_step = (state_r == ST_EMIT) && stat.conv_busy;
    cmd.advance   = out_valid && out_ready;
    state_nxt     = state_r;
    case (state_r)
      ST_IDLE: begin
        // unknown ops are taken and dropped
        if (cmd.load) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd.advance && stat.byte_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/lsfw_dp.sv
// Datapath of the LCD serial frame writer: held request, decimal digit
// unit, digit store and byte selection. Depends on lsfw_pkg.
module lsfw_dp import lsfw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [OP_W-1:0]    in_op,
  input  logic [VALUE_W-1:0] in_value,
  input  logic [ROW_W-1:0]   in_row,
  input  logic [COL_W-1:0]   in_col,
  output logic [BYTE_W-1:0]  out_serial_byte,
  output logic               out_last,
  input  lsfw_cmd_t          cmd,
  output lsfw_stat_t         stat
);

  logic [OP_W-1:0]    op_r;
  logic [VALUE_W-1:0] value_r;
  logic [ROW_W-1:0]   row_r;
  logic [COL_W-1:0]   col_r;
  logic [VALUE_W-1:0] work_r, work_nxt;
  logic [2:0]         conv_cnt_r;
  logic [2:0]         frame_r;
  logic [1:0]         phase_r;
  logic [BYTE_W-1:0]  digit_store_r [NDIG_MAX];

  logic [2:0]         ndig;
  logic [2:0]         nframes;
  logic [2:0]         dig_idx;
  logic [32:0]        prod;
  logic [VALUE_W-1:0] q10;
  logic [3:0]         rem;
  logic [BYTE_W-1:0]  dig_char;
  logic [BYTE_W-1:0]  cursor;
  logic [BYTE_W-1:0]  frame_byte;
  logic               frame0_cmd;

  always_comb begin
    case (op_r)
      OP_NUM4: begin ndig = 3'd4; nframes = 3'd5; end
      OP_NUM5: begin ndig = 3'd5; nframes = 3'd6; end
      default: begin ndig = 3'd0; nframes = 3'd1; end
    endcase
  end

  // Divide-by-ten step: digits come out lowest first
  assign prod     = work_r * DIV10_MUL;
  assign work_nxt = VALUE_W'(prod[32:DIV10_SHIFT]);
  assign q10      = (work_nxt << 3) + (work_nxt << 1);
  assign rem      = 4'(work_r - q10);
  assign dig_idx  = ndig - 3'd1 - conv_cnt_r;
  // the leading digit is whatever quotient remains, unclamped
  assign dig_char = (dig_idx == 3'd0) ? ASCII_0 + work_r[BYTE_W-1:0]
                                      : ASCII_0 + {4'd0, rem};

  always_comb begin
    case (row_r)
      ROW_1:   cursor = ROW1_BASE + {4'd0, col_r};
      ROW_2:   cursor = ROW2_BASE + {4'd0, col_r};
      ROW_3:   cursor = ROW3_BASE + {4'd0, col_r};
      ROW_4:   cursor = ROW4_BASE + {4'd0, col_r};
      default: cursor = '0;
    endcase
  end

  always_comb begin
    frame0_cmd = (op_r != OP_DATA);
    if (frame_r == 3'd0) begin
      frame_byte = (op_r == OP_CMD || op_r == OP_DATA) ? value_r[BYTE_W-1:0] : cursor;
    end else begin
      frame_byte = digit_store_r[frame_r - 3'd1];
    end
    case (phase_r)
      2'd0:    out_serial_byte = (frame_r == 3'd0 && frame0_cmd) ? SYNC_CMD : SYNC_DATA;
      2'd1:    out_serial_byte = frame_byte & NIB_MASK;
      default: out_serial_byte = {frame_byte[3:0], 4'd0};
    endcase
  end

  always_comb begin
    stat.in_op_ok  = (in_op <= OP_NUM5);
    stat.conv_busy = (conv_cnt_r != ndig);
    stat.byte_ok   = (frame_r == 3'd0) || !stat.conv_busy;
    stat.byte_last = (phase_r == 2'd2) && (frame_r == nframes - 3'd1);
  end
  assign out_last = stat.byte_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r    <= '0;
      value_r <= '0;
      row_r   <= '0;
      col_r   <= '0;
      work_r  <= '0;
    end else if (cmd.load) begin
      op_r    <= in_op;
      value_r <= in_value;
      row_r   <= in_row;
      col_r   <= in_col;
      work_r  <= in_value;
    end else if (cmd.conv_step) begin
      digit_store_r[dig_idx] <= dig_char;
      work_r                 <= work_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_cnt_r <= '0;
      frame_r    <= '0;
      phase_r    <= '0;
    end else if (cmd.load) begin
      conv_cnt_r <= '0;
      frame_r    <= '0;
      phase_r    <= '0;
    end else begin
      if (cmd.conv_step) conv_cnt_r <= conv_cnt_r + 3'd1;
      if (cmd.advance) begin
        if (phase_r == 2'd2) begin
          phase_r <= '0;
          frame_r <= frame_r + 3'd1;
        end else begin
          phase_r <= phase_r + 2'd1;
        end
      end
    end
  end

endmodule

FILE: tb/lsfw_frame_checker.sv
// Frame checker for the LCD serial frame writer: watches both channels,
// predicts the serial bytes of each request and compares them in order.
// Depends on lsfw_pkg and the channel interfaces in lsfw_if.
module lsfw_frame_checker import lsfw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  lsfw_in_if   in_mon,
  lsfw_out_if  out_mon,
  output int   fail_count,
  output int   pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [BYTE_W-1:0] serial_byte;
    logic              last;
  } lcd_byte_t;

  lcd_byte_t         frame_q[$];
  logic [26:0]       held_request = '0;
  logic [4:0]        request_bytes = '0;
  logic [BYTE_W-1:0] digit_chars[NDIG_MAX];

  function automatic logic [BYTE_W-1:0] cursor_byte(logic [ROW_W-1:0] row,
                                                    logic [COL_W-1:0] col);
    case (row)
      ROW_1:   return ROW1_BASE + BYTE_W'(col);
      ROW_2:   return ROW2_BASE + BYTE_W'(col);
      ROW_3:   return ROW3_BASE + BYTE_W'(col);
      ROW_4:   return ROW4_BASE + BYTE_W'(col);
      default: return '0;
    endcase
  endfunction

  // Sync byte, high nibble, low nibble moved up; last only on the third.
  task automatic push_frame(logic [BYTE_W-1:0] sync, logic [BYTE_W-1:0] b,
                            logic ends_request);
    frame_q.push_back('{serial_byte: sync, last: 1'b0});
    frame_q.push_back('{serial_byte: b & NIB_MASK, last: 1'b0});
    frame_q.push_back('{serial_byte: (b << 4) & NIB_MASK, last: ends_request});
    request_bytes = request_bytes + 5'd3;
  endtask

  task automatic predict_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                                 logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
    int v;
    int ndig;
    v    = int'(value);
    ndig = 0;
    if (op > OP_NUM5) return;
    // bit 22 stays clear between row and col
    held_request  = {col, 1'b0, row, value, op};
    request_bytes = '0;
    case (op)
      OP_CMD:  push_frame(SYNC_CMD, value[BYTE_W-1:0], 1'b1);
      OP_DATA: push_frame(SYNC_DATA, value[BYTE_W-1:0], 1'b1);
      default: begin
        if (op == OP_NUM4) begin
          // leading digit is not clamped: values past 9999 go beyond '9'
          digit_chars[0] = ASCII_0 + BYTE_W'(v / 1000);
          digit_chars[1] = ASCII_0 + BYTE_W'(v % 1000 / 100);
          digit_chars[2] = ASCII_0 + BYTE_W'(v % 100 / 10);
          digit_chars[3] = ASCII_0 + BYTE_W'(v % 10);
          ndig = 4;
        end else if (op == OP_NUM5) begin
          digit_chars[0] = ASCII_0 + BYTE_W'(v / 10000);
          digit_chars[1] = ASCII_0 + BYTE_W'(v % 10000 / 1000);
          digit_chars[2] = ASCII_0 + BYTE_W'(v % 1000 / 100);
          digit_chars[3] = ASCII_0 + BYTE_W'(v % 100 / 10);
          digit_chars[4] = ASCII_0 + BYTE_W'(v % 10);
          ndig = 5;
        end
        push_frame(SYNC_CMD, cursor_byte(row, col), ndig == 0);
        for (int i = 0; i < ndig; i++)
          push_frame(SYNC_DATA, digit_chars[i], i == ndig - 1);
      end
    endcase
  endtask

  always @(posedge clk) begin : watch_channels
    lcd_byte_t want;
    if (rst_n) begin
      // Bytes taken at this edge belong to earlier requests: check them first.
      if (out_mon.valid && out_mon.ready) begin
        if (frame_q.size() == 0) begin
          $error("serial_byte: expected none, actual %h", out_mon.serial_byte);
          fail_count++;
        end else begin
          want = frame_q.pop_front();
          if (out_mon.serial_byte !== want.serial_byte) begin
            $error("serial_byte: expected %h, actual %h (request %h)",
                   want.serial_byte, out_mon.serial_byte, held_request);
            fail_count++;
          end
          if (out_mon.last !== want.last) begin
            $error("last: expected %b, actual %b (request %h)",
                   want.last, out_mon.last, held_request);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_request(in_mon.op, in_mon.value, in_mon.row, in_mon.col);
    end
    pending_count = frame_q.size();
  end

endmodule

FILE: tb/testbench.sv
// Top of the LCD serial frame writer testbench: clock, reset, request
// stimulus, byte-side back-pressure and the verdict.
// Depends on lsfw_pkg, lsfw_if, the block and lsfw_frame_checker.
module testbench import lsfw_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n;

  // Chance, in percent per cycle, that the request side holds off and
  // that the byte side stalls. Changed between phases.
  int send_idle_pct = 0;
  int stall_pct     = 0;

  int fail_count;
  int pending_count;
  int sent;

  lsfw_in_if  in_ch ();
  lsfw_out_if out_ch ();

  lcd_serial_frame_writer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_ch.sink),
    .out_rsp (out_ch.source)
  );

  lsfw_frame_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stall the byte side at random; change only on the falling edge.
  initial begin : byte_side
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one request and hold it until the block takes it. Any hold-off
  // comes first, so valid is never dropped and raised in one step.
  task automatic send_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                              logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.value <= value;
    in_ch.row   <= row;
    in_ch.col   <= col;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Random request: mostly known ops with random content, a few unknown
  // codes as noise. Return whether the request can produce bytes.
  task automatic send_random_request(output logic counted);
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    logic [ROW_W-1:0]   row;
    if ($urandom_range(99) < 8)
      op = OP_W'($urandom_range(7, 5));
    else
      op = OP_W'($urandom_range(4, 0));
    case ($urandom_range(5))
      0:       value = VALUE_W'($urandom_range(9999));
      1:       value = ($urandom_range(1)) ? '1 : '0;
      2:       value = VALUE_W'($urandom_range(10000, 9990));
      default: value = VALUE_W'($urandom);
    endcase
    // Favor real display lines; keep some rows that give address zero.
    if ($urandom_range(99) < 75)
      row = ROW_W'($urandom_range(4, 1));
    else
      row = ROW_W'($urandom_range(7));
    send_request(op, value, row, COL_W'($urandom_range(15)));
    counted = (op <= OP_NUM5);
  endtask

  initial begin : stimulus
    logic counted;
    // Drive every input to a known value before the first edge.
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op    = OP_CMD;
    in_ch.value = '0;
    in_ch.row   = '0;
    in_ch.col   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed requests under light two-sided idling.
    send_idle_pct = 31;
    stall_pct     = 31;
    send_request(OP_CMD, 16'h0000, 3'd0, 4'd0);
    send_request(OP_CMD, 16'h00FF, 3'd7, 4'd15);
    send_request(OP_CMD, 16'hFFFF, 3'd1, 4'd0);   // upper byte must be dropped
    send_request(OP_CMD, 16'h5AA5, 3'd2, 4'd5);
    send_request(OP_DATA, 16'h0000, 3'd0, 4'd0);
    send_request(OP_DATA, 16'h00FF, 3'd3, 4'd9);
    send_request(OP_DATA, 16'h1234, 3'd4, 4'd3);
    for (int r = 0; r < 8; r++)
      send_request(OP_CURS, 16'hFFFF, ROW_W'(r), (r % 2 == 0) ? 4'd0 : 4'd15);
    send_request(OP_NUM4, 16'd0, 3'd1, 4'd0);
    send_request(OP_NUM4, 16'd9999, 3'd4, 4'd15);
    send_request(OP_NUM4, 16'd10000, 3'd2, 4'd4); // leading digit past '9'
    send_request(OP_NUM4, 16'd65535, 3'd5, 4'd7); // unclamped, off-line row
    send_request(OP_NUM5, 16'd0, 3'd3, 4'd1);
    send_request(OP_NUM5, 16'd65535, 3'd4, 4'd15);
    send_request(OP_NUM5, 16'd12345, 3'd0, 4'd2);
    send_request(3'd5, 16'hFFFF, 3'd7, 4'd15);    // unknown codes: no bytes
    send_request(3'd6, 16'h0000, 3'd1, 4'd0);
    send_request(3'd7, 16'hA5A5, 3'd2, 4'd8);

    // Random requests in four idling phases: none, sender only,
    // receiver only, both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 47; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 47; end
        default: begin send_idle_pct = 31; stall_pct = 31; end
      endcase
      sent = 0;
      while (sent < 20) begin
        send_random_request(counted);
        if (counted) sent++;
      end
    end
    in_ch.valid <= 1'b0;

    // Drain every expected byte, then let an ignored request settle.
    while (pending_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Stop a hung run well past the slowest legal one.
  initial begin : watchdog
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
